### rtl/htsc_pkg.sv
// Shared constants, register codes and calibration type for the sensor compensation block.
package htsc_pkg;

    localparam int ADDR_W      = 5;
    localparam int STAGES      = 10;
    localparam int TEMP_STAGES = 3;
    localparam int POST_STAGES = STAGES - TEMP_STAGES;

    // Register indexes, taken from paddr[4:2]
    localparam logic [2:0] REG_CAL_T1    = 3'd0;
    localparam logic [2:0] REG_CAL_T2    = 3'd1;
    localparam logic [2:0] REG_CAL_T3    = 3'd2;
    localparam logic [2:0] REG_CAL_H1    = 3'd3;
    localparam logic [2:0] REG_CAL_H2    = 3'd4;
    localparam logic [2:0] REG_CAL_H3    = 3'd5;
    localparam logic [2:0] REG_CAL_H4_H5 = 3'd6;
    localparam logic [2:0] REG_CAL_H6    = 3'd7;

    localparam logic signed [31:0] HUM_T_OFFSET = 32'sd76800;
    localparam logic signed [31:0] ROUND_P      = 32'sd16384;
    localparam logic signed [31:0] Q_OFFSET_A   = 32'sd32768;
    localparam logic signed [31:0] Q_OFFSET_B   = 32'sd2097152;
    localparam logic signed [31:0] ROUND_Q      = 32'sd8192;
    localparam logic signed [31:0] HUM_MAX      = 32'sd419430400;
    localparam logic signed [31:0] CENTI_ROUND  = 32'sd128;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [7:0]  h3;
        logic signed [11:0] h4;
        logic signed [11:0] h5;
        logic signed [7:0]  h6;
    } cal_t;

endpackage

### rtl/htsc_cfg_regs.sv
// APB calibration register file.
module htsc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output htsc_pkg::cal_t                cal
);

    logic [15:0] t1_reg;
    logic [15:0] t2_reg;
    logic [15:0] t3_reg;
    logic [7:0]  h1_reg;
    logic [15:0] h2_reg;
    logic [7:0]  h3_reg;
    logic [23:0] h45_reg;
    logic [7:0]  h6_reg;
    logic [2:0]  idx;
    logic        wr;

    assign idx    = paddr[htsc_pkg::ADDR_W-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            t3_reg  <= '0;
            h1_reg  <= '0;
            h2_reg  <= '0;
            h3_reg  <= '0;
            h45_reg <= '0;
            h6_reg  <= '0;
        end
        else if (wr)
        begin
            unique case (idx)
                htsc_pkg::REG_CAL_T1:    t1_reg  <= pwdata[15:0];
                htsc_pkg::REG_CAL_T2:    t2_reg  <= pwdata[15:0];
                htsc_pkg::REG_CAL_T3:    t3_reg  <= pwdata[15:0];
                htsc_pkg::REG_CAL_H1:    h1_reg  <= pwdata[7:0];
                htsc_pkg::REG_CAL_H2:    h2_reg  <= pwdata[15:0];
                htsc_pkg::REG_CAL_H3:    h3_reg  <= pwdata[7:0];
                htsc_pkg::REG_CAL_H4_H5: h45_reg <= pwdata[23:0];
                htsc_pkg::REG_CAL_H6:    h6_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            htsc_pkg::REG_CAL_T1:    prdata = {16'd0, t1_reg};
            htsc_pkg::REG_CAL_T2:    prdata = {16'd0, t2_reg};
            htsc_pkg::REG_CAL_T3:    prdata = {16'd0, t3_reg};
            htsc_pkg::REG_CAL_H1:    prdata = {24'd0, h1_reg};
            htsc_pkg::REG_CAL_H2:    prdata = {16'd0, h2_reg};
            htsc_pkg::REG_CAL_H3:    prdata = {24'd0, h3_reg};
            htsc_pkg::REG_CAL_H4_H5: prdata = {8'd0, h45_reg};
            htsc_pkg::REG_CAL_H6:    prdata = {24'd0, h6_reg};
            default:                 prdata = '0;
        endcase
    end

    always_comb
    begin
        cal.t1 = t1_reg;
        cal.t2 = $signed(t2_reg);
        cal.t3 = $signed(t3_reg);
        cal.h1 = h1_reg;
        cal.h2 = $signed(h2_reg);
        cal.h3 = h3_reg;
        cal.h4 = $signed(h45_reg[23:12]);
        cal.h5 = $signed(h45_reg[11:0]);
        cal.h6 = $signed(h6_reg);
    end

endmodule

### rtl/htsc_pipe_ctrl.sv
// Per-stage valid bits and load enables for the compensation pipeline.
module htsc_pipe_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [htsc_pkg::STAGES-1:0]   en
);

    logic [htsc_pkg::STAGES-1:0] valid_reg;
    logic [htsc_pkg::STAGES-1:0] valid_next;
    logic                        in_acc;
    logic                        out_acc;

    // A stage may load when it is empty or its content moves on this cycle
    always_comb
    begin
        en[htsc_pkg::STAGES-1] = !valid_reg[htsc_pkg::STAGES-1] || result_ready;
        for (int i = htsc_pkg::STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? sample_valid : valid_reg[0];
        for (int i = 1; i < htsc_pkg::STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign sample_ready = en[0];
    assign result_valid = valid_reg[htsc_pkg::STAGES-1];
    assign in_acc       = sample_valid && sample_ready;
    assign out_acc      = result_valid && result_ready;

    // Back-pressure reaches the input only once every stage holds an item
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (&valid_reg))
        else $error("input blocked with a bubble in the pipeline");

    // Items in flight change only by accepted input and delivered output
    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("item lost or duplicated in the pipeline");

    a_first_stage_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> valid_reg[0])
        else $error("accepted item missing from the first stage");

endmodule

### rtl/htsc_temp.sv
// Temperature stages: fine temperature and the humidity temperature term.
module htsc_temp (
    input  logic                               clk,
    input  logic [htsc_pkg::TEMP_STAGES-1:0]   en,
    input  htsc_pkg::cal_t                     cal,
    input  logic [19:0]                        raw_temperature,
    input  logic [15:0]                        raw_humidity,
    output logic signed [31:0]                 fine,
    output logic signed [31:0]                 var_t,
    output logic [15:0]                        raw_h
);

    logic signed [31:0] x1;
    logic signed [31:0] d1;
    logic signed [31:0] t2s;
    logic signed [31:0] t3s;
    logic signed [31:0] fine_c;

    logic signed [31:0] s1_m1_reg;
    logic signed [31:0] s1_dd_reg;
    logic [15:0]        s1_rh_reg;
    logic signed [31:0] s2_a1_reg;
    logic signed [31:0] s2_m2_reg;
    logic [15:0]        s2_rh_reg;
    logic signed [31:0] s3_fine_reg;
    logic signed [31:0] s3_var_reg;
    logic [15:0]        s3_rh_reg;

    assign t2s = $signed({{16{cal.t2[15]}}, cal.t2});
    assign t3s = $signed({{16{cal.t3[15]}}, cal.t3});
    assign x1  = $signed({15'd0, raw_temperature[19:3]}) - $signed({15'd0, cal.t1, 1'b0});
    assign d1  = $signed({16'd0, raw_temperature[19:4]}) - $signed({16'd0, cal.t1});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_m1_reg <= x1 * t2s;
            s1_dd_reg <= d1 * d1;
            s1_rh_reg <= raw_humidity;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_a1_reg <= s1_m1_reg >>> 11;
            s2_m2_reg <= (s1_dd_reg >>> 12) * t3s;
            s2_rh_reg <= s1_rh_reg;
        end
    end

    assign fine_c = s2_a1_reg + (s2_m2_reg >>> 14);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_fine_reg <= fine_c;
            s3_var_reg  <= fine_c - htsc_pkg::HUM_T_OFFSET;
            s3_rh_reg   <= s2_rh_reg;
        end
    end

    assign fine  = s3_fine_reg;
    assign var_t = s3_var_reg;
    assign raw_h = s3_rh_reg;

endmodule

### rtl/htsc_humid.sv
// Humidity stages, centi-degree conversion and the final clamp.
module htsc_humid (
    input  logic                               clk,
    input  logic [htsc_pkg::POST_STAGES-1:0]   en,
    input  htsc_pkg::cal_t                     cal,
    input  logic signed [31:0]                 fine,
    input  logic signed [31:0]                 var_t,
    input  logic [15:0]                        raw_h,
    output logic signed [31:0]                 fine_temperature,
    output logic signed [23:0]                 temperature_centi,
    output logic [16:0]                        humidity_q10
);

    logic signed [31:0] h1s;
    logic signed [31:0] h2s;
    logic signed [31:0] h3s;
    logic signed [31:0] h5s;
    logic signed [31:0] h6s;
    logic signed [31:0] c4;
    logic signed [31:0] p_sum;
    logic signed [31:0] q7;
    logic signed [31:0] s8_s;
    logic signed [31:0] r10;
    logic signed [31:0] clamp10;

    logic signed [31:0] fine_reg  [htsc_pkg::POST_STAGES];
    logic signed [23:0] centi_reg [htsc_pkg::POST_STAGES];

    logic signed [31:0] s4_hv_reg;
    logic signed [31:0] s4_m6_reg;
    logic signed [31:0] s4_m3_reg;
    logic [15:0]        s4_rh_reg;
    logic signed [31:0] s5_p_reg;
    logic signed [31:0] s5_q0_reg;
    logic signed [31:0] s6_p_reg;
    logic signed [31:0] s6_mq_reg;
    logic signed [31:0] s7_v_reg;
    logic signed [31:0] s8_v_reg;
    logic signed [31:0] s8_ss_reg;
    logic signed [31:0] s9_v_reg;
    logic signed [31:0] s9_t_reg;
    logic [16:0]        s10_hum_reg;

    assign h1s = $signed({24'd0, cal.h1});
    assign h2s = $signed({{16{cal.h2[15]}}, cal.h2});
    assign h3s = $signed({24'd0, cal.h3});
    assign h5s = $signed({{20{cal.h5[11]}}, cal.h5});
    assign h6s = $signed({{24{cal.h6[7]}}, cal.h6});

    // fine * 5 + 128, then >> 8 keeps bits 31..8
    assign c4 = (fine <<< 2) + fine + htsc_pkg::CENTI_ROUND;

    // fine and centi ride along to the output stage
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            fine_reg[0]  <= fine;
            centi_reg[0] <= c4[31:8];
        end
        for (int k = 1; k < htsc_pkg::POST_STAGES; k++)
        begin
            if (en[k])
            begin
                fine_reg[k]  <= fine_reg[k-1];
                centi_reg[k] <= centi_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s4_hv_reg <= h5s * var_t;
            s4_m6_reg <= var_t * h6s;
            s4_m3_reg <= var_t * h3s;
            s4_rh_reg <= raw_h;
        end
    end

    // (raw << 14) - (h4 << 20) - h5*v + 16384, low 32 bits
    assign p_sum = $signed({2'd0, s4_rh_reg, 14'd0}) - $signed({cal.h4, 20'd0})
                   - s4_hv_reg + htsc_pkg::ROUND_P;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s5_p_reg  <= p_sum >>> 15;
            s5_q0_reg <= (s4_m6_reg >>> 10) * ((s4_m3_reg >>> 11) + htsc_pkg::Q_OFFSET_A);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s6_p_reg  <= s5_p_reg;
            s6_mq_reg <= ((s5_q0_reg >>> 10) + htsc_pkg::Q_OFFSET_B) * h2s;
        end
    end

    assign q7 = (s6_mq_reg + htsc_pkg::ROUND_Q) >>> 14;

    always_ff @(posedge clk)
    begin
        if (en[3])
            s7_v_reg <= s6_p_reg * q7;
    end

    assign s8_s = s7_v_reg >>> 15;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s8_ss_reg <= s8_s * s8_s;
            s8_v_reg  <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s9_t_reg <= (s8_ss_reg >>> 7) * h1s;
            s9_v_reg <= s8_v_reg;
        end
    end

    assign r10 = s9_v_reg - (s9_t_reg >>> 4);

    always_comb
    begin
        if (r10[31])
            clamp10 = '0;
        else if (r10 > htsc_pkg::HUM_MAX)
            clamp10 = htsc_pkg::HUM_MAX;
        else
            clamp10 = r10;
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
            s10_hum_reg <= clamp10[28:12];
    end

    assign fine_temperature  = fine_reg[htsc_pkg::POST_STAGES-1];
    assign temperature_centi = centi_reg[htsc_pkg::POST_STAGES-1];
    assign humidity_q10      = s10_hum_reg;

endmodule

### rtl/humidity_temp_sensor_compensation.sv
// Top level: integer temperature and humidity compensation pipeline with APB calibration port.
// One item (raw temperature and raw humidity) enters per clock cycle while sample_ready
// is high, and its result leaves through the ten register stages; each holds at most one
// layer of 32-bit multiplies, and the longest chain (fine temperature, then six dependent
// humidity multiplies and the clamp) sets the number of stages. Each stage holds an item
// until the next stage frees, so a stalled output fills the empty stages before the
// input sees back-pressure. Calibration registers sit at byte addresses 0x00..0x1C
// (t1, t2, t3, h1, h2, h3, packed h4/h5, h6) and read back their field bits with the
// upper bits as zero; change them only while no item is in flight.
module humidity_temp_sensor_compensation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [htsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic [19:0]                   raw_temperature,
    input  logic [15:0]                   raw_humidity,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [31:0]            fine_temperature,
    output logic signed [23:0]            temperature_centi,
    output logic [16:0]                   humidity_q10
);

    htsc_pkg::cal_t               cal;
    logic [htsc_pkg::STAGES-1:0]  en;
    logic signed [31:0]           fine;
    logic signed [31:0]           var_t;
    logic [15:0]                  raw_h;

    htsc_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    htsc_pipe_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .en           (en)
    );

    htsc_temp u_temp (
        .clk             (clk),
        .en              (en[htsc_pkg::TEMP_STAGES-1:0]),
        .cal             (cal),
        .raw_temperature (raw_temperature),
        .raw_humidity    (raw_humidity),
        .fine            (fine),
        .var_t           (var_t),
        .raw_h           (raw_h)
    );

    htsc_humid u_humid (
        .clk               (clk),
        .en                (en[htsc_pkg::STAGES-1:htsc_pkg::TEMP_STAGES]),
        .cal               (cal),
        .fine              (fine),
        .var_t             (var_t),
        .raw_h             (raw_h),
        .fine_temperature  (fine_temperature),
        .temperature_centi (temperature_centi),
        .humidity_q10      (humidity_q10)
    );

endmodule

### bench/compensation_checker.sv
// Result checker: tracks calibration writes, predicts each compensated reading and compares.
`timescale 1ns / 100ps

module compensation_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [htsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    input  logic                          sample_valid,
    input  logic                          sample_ready,
    input  logic [19:0]                   raw_temperature,
    input  logic [15:0]                   raw_humidity,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  logic signed [31:0]            fine_temperature,
    input  logic signed [23:0]            temperature_centi,
    input  logic [16:0]                   humidity_q10,
    output int                            mismatches,
    output int                            outstanding,
    output int                            checked,
    output int                            zero_hits,
    output int                            full_hits
);

    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] centi;
        logic        [16:0] hum;
    } reading_t;

    htsc_pkg::cal_t cal;
    reading_t       expected_readings[$];
    int             err_count;
    int             check_count;
    int             zero_count;
    int             full_count;

    // All intermediates are 32-bit signed words; products wrap, >>> copies the sign.
    function automatic reading_t compensate_reading(input logic [19:0] rt,
                                                    input logic [15:0] rh,
                                                    input htsc_pkg::cal_t c);
        logic signed [31:0] adc_t, adc_h;
        logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic signed [31:0] a1, d, a2, fine, centi, v, p, q, s;
        reading_t r;
        adc_t = {12'd0, rt};
        adc_h = {16'd0, rh};
        t1 = {16'd0, c.t1};
        t2 = {{16{c.t2[15]}}, c.t2};
        t3 = {{16{c.t3[15]}}, c.t3};
        h1 = {24'd0, c.h1};
        h2 = {{16{c.h2[15]}}, c.h2};
        h3 = {24'd0, c.h3};
        h4 = {{20{c.h4[11]}}, c.h4};
        h5 = {{20{c.h5[11]}}, c.h5};
        h6 = {{24{c.h6[7]}}, c.h6};

        a1 = (((adc_t >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = (adc_t >>> 4) - t1;
        a2 = (((d * d) >>> 12) * t3) >>> 14;
        fine = a1 + a2;
        centi = (fine * 32'sd5 + htsc_pkg::CENTI_ROUND) >>> 8;

        v = fine - htsc_pkg::HUM_T_OFFSET;
        p = (((adc_h <<< 14) - (h4 <<< 20) - (h5 * v)) + htsc_pkg::ROUND_P) >>> 15;
        q = ((v * h6) >>> 10) * (((v * h3) >>> 11) + htsc_pkg::Q_OFFSET_A);
        q = (q >>> 10) + htsc_pkg::Q_OFFSET_B;
        q = ((q * h2) + htsc_pkg::ROUND_Q) >>> 14;
        v = p * q;
        s = v >>> 15;
        v = v - ((((s * s) >>> 7) * h1) >>> 4);
        if (v < 0)
            v = 0;
        if (v > htsc_pkg::HUM_MAX)
            v = htsc_pkg::HUM_MAX;

        r.fine = fine;
        r.centi = centi[23:0];
        r.hum = v[28:12];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t want;
        if (!rst_n)
        begin
            cal = '0;
            expected_readings.delete();
            err_count = 0;
            check_count = 0;
            zero_count = 0;
            full_count = 0;
        end
        else
        begin
            // item in: predict with the calibration in force before any write this edge
            if (sample_valid && sample_ready)
            begin
                want = compensate_reading(raw_temperature, raw_humidity, cal);
                expected_readings.push_back(want);
                if (want.hum == 0)
                    zero_count++;
                if (want.hum == 17'd102400)
                    full_count++;
            end

            if (result_valid && result_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    $display("%0t: result with no item pending: fine %0d centi %0d hum %0d",
                             $time, fine_temperature, temperature_centi, humidity_q10);
                    err_count++;
                end
                else
                begin
                    want = expected_readings.pop_front();
                    check_count++;
                    if (fine_temperature !== want.fine)
                    begin
                        $display("%0t: fine_temperature expected %0d, got %0d",
                                 $time, want.fine, fine_temperature);
                        err_count++;
                    end
                    if (temperature_centi !== want.centi)
                    begin
                        $display("%0t: temperature_centi expected %0d, got %0d",
                                 $time, want.centi, temperature_centi);
                        err_count++;
                    end
                    if (humidity_q10 !== want.hum)
                    begin
                        $display("%0t: humidity_q10 expected %0d, got %0d",
                                 $time, want.hum, humidity_q10);
                        err_count++;
                    end
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[htsc_pkg::ADDR_W-1:2])
                    htsc_pkg::REG_CAL_T1:    cal.t1 = pwdata[15:0];
                    htsc_pkg::REG_CAL_T2:    cal.t2 = pwdata[15:0];
                    htsc_pkg::REG_CAL_T3:    cal.t3 = pwdata[15:0];
                    htsc_pkg::REG_CAL_H1:    cal.h1 = pwdata[7:0];
                    htsc_pkg::REG_CAL_H2:    cal.h2 = pwdata[15:0];
                    htsc_pkg::REG_CAL_H3:    cal.h3 = pwdata[7:0];
                    htsc_pkg::REG_CAL_H4_H5:
                    begin
                        cal.h4 = pwdata[23:12];
                        cal.h5 = pwdata[11:0];
                    end
                    htsc_pkg::REG_CAL_H6:    cal.h6 = pwdata[7:0];
                    default:                 ;
                endcase
            end
        end

        // outputs move after the edge so the stimulus side reads settled values
        mismatches <= err_count;
        outstanding <= expected_readings.size();
        checked <= check_count;
        zero_hits <= zero_count;
        full_hits <= full_count;
    end

endmodule

### bench/humidity_temp_sensor_compensation_test.sv
// Testbench top: clock, reset, calibration writes, sample stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module humidity_temp_sensor_compensation_test;

    typedef enum int {CAL_DATASHEET, CAL_NEAR, CAL_WIDE, CAL_MAX, CAL_MIN} cal_kind_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [htsc_pkg::ADDR_W-1:0]    paddr = '0;
    logic [31:0]                    pwdata = '0;
    logic [31:0]                    prdata;
    logic                           pready;
    logic                           sample_valid = 1'b0;
    logic                           sample_ready;
    logic [19:0]                    raw_temperature = '0;
    logic [15:0]                    raw_humidity = '0;
    logic                           result_valid;
    logic                           result_ready = 1'b0;
    logic signed [31:0]             fine_temperature;
    logic signed [23:0]             temperature_centi;
    logic [16:0]                    humidity_q10;

    int mismatches;
    int outstanding;
    int checked;
    int zero_hits;
    int full_hits;

    int burst_left = 0;
    int samples_sent = 0;
    int settings_loaded = 0;

    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    humidity_temp_sensor_compensation uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .raw_temperature   (raw_temperature),
        .raw_humidity      (raw_humidity),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .fine_temperature  (fine_temperature),
        .temperature_centi (temperature_centi),
        .humidity_q10      (humidity_q10)
    );

    compensation_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .pready            (pready),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .sample_valid      (sample_valid),
        .sample_ready      (sample_ready),
        .raw_temperature   (raw_temperature),
        .raw_humidity      (raw_humidity),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .fine_temperature  (fine_temperature),
        .temperature_centi (temperature_centi),
        .humidity_q10      (humidity_q10),
        .mismatches        (mismatches),
        .outstanding       (outstanding),
        .checked           (checked),
        .zero_hits         (zero_hits),
        .full_hits         (full_hits)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: stall behavior changes each time a random stall_span runs out
    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(50, 300);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= ($urandom_range(0, 3) != 0);
            2:       result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= ((stall_tick % 7) < 4);
        endcase
    end

    function automatic htsc_pkg::cal_t make_cal(input cal_kind_t kind);
        htsc_pkg::cal_t c;
        logic [127:0]   noise;
        case (kind)
            CAL_DATASHEET:
            begin
                c.t1 = 16'd27504;  c.t2 = 16'sd26435; c.t3 = -16'sd1000;
                c.h1 = 8'd75;      c.h2 = 16'sd362;   c.h3 = 8'd0;
                c.h4 = 12'sd313;   c.h5 = 12'sd50;    c.h6 = 8'sd30;
            end
            CAL_NEAR:
            begin
                c.t1 = 16'(27504 + int'($urandom_range(0, 4000)) - 2000);
                c.t2 = 16'(26435 + int'($urandom_range(0, 4000)) - 2000);
                c.t3 = 16'(-1000 + int'($urandom_range(0, 1000)) - 500);
                c.h1 = 8'($urandom_range(0, 255));
                c.h2 = 16'(300 + int'($urandom_range(0, 120)));
                c.h3 = 8'($urandom_range(0, 255));
                c.h4 = 12'(250 + int'($urandom_range(0, 130)));
                c.h5 = 12'(int'($urandom_range(0, 120)) - 20);
                c.h6 = 8'(int'($urandom_range(0, 90)) - 30);
            end
            CAL_MAX:
            begin
                c.t1 = 16'hFFFF;   c.t2 = 16'sh7FFF;  c.t3 = 16'sh7FFF;
                c.h1 = 8'hFF;      c.h2 = 16'sh7FFF;  c.h3 = 8'hFF;
                c.h4 = 12'sh7FF;   c.h5 = 12'sh7FF;   c.h6 = 8'sh7F;
            end
            CAL_MIN:
            begin
                c.t1 = 16'h0000;   c.t2 = 16'sh8000;  c.t3 = 16'sh8000;
                c.h1 = 8'h00;      c.h2 = 16'sh8000;  c.h3 = 8'h00;
                c.h4 = 12'sh800;   c.h5 = 12'sh800;   c.h6 = 8'sh80;
            end
            default:
            begin
                noise = {$urandom, $urandom, $urandom, $urandom};
                c = noise[$bits(htsc_pkg::cal_t)-1:0];
            end
        endcase
        return c;
    endfunction

    // write all eight calibration registers; bits above each width get junk
    task automatic load_cal(input htsc_pkg::cal_t c);
        logic [31:0] regval [8];
        logic [31:0] keep [8];
        logic [2:0]  idx;
        regval[htsc_pkg::REG_CAL_T1] = {16'd0, c.t1};
        keep[htsc_pkg::REG_CAL_T1]   = 32'h0000FFFF;
        regval[htsc_pkg::REG_CAL_T2] = {16'd0, c.t2};
        keep[htsc_pkg::REG_CAL_T2]   = 32'h0000FFFF;
        regval[htsc_pkg::REG_CAL_T3] = {16'd0, c.t3};
        keep[htsc_pkg::REG_CAL_T3]   = 32'h0000FFFF;
        regval[htsc_pkg::REG_CAL_H1] = {24'd0, c.h1};
        keep[htsc_pkg::REG_CAL_H1]   = 32'h000000FF;
        regval[htsc_pkg::REG_CAL_H2] = {16'd0, c.h2};
        keep[htsc_pkg::REG_CAL_H2]   = 32'h0000FFFF;
        regval[htsc_pkg::REG_CAL_H3] = {24'd0, c.h3};
        keep[htsc_pkg::REG_CAL_H3]   = 32'h000000FF;
        regval[htsc_pkg::REG_CAL_H4_H5] = {8'd0, c.h4, c.h5};
        keep[htsc_pkg::REG_CAL_H4_H5]   = 32'h00FFFFFF;
        regval[htsc_pkg::REG_CAL_H6] = {24'd0, c.h6};
        keep[htsc_pkg::REG_CAL_H6]   = 32'h000000FF;
        for (int k = 0; k < 8; k++)
        begin
            idx = k[2:0];
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {idx, 2'b00};
            pwdata <= regval[k] | ($urandom & ~keep[k]);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(posedge clk);
        end
        settings_loaded++;
    endtask

    task automatic send_sample(input logic [19:0] rt, input logic [15:0] rh);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            burst_left = $urandom_range(1, 48);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sample_valid <= 1'b1;
        raw_temperature <= rt;
        raw_humidity <= rh;
        do
            @(posedge clk);
        while (!sample_ready);
        samples_sent++;
    endtask

    // drain: wait for a clock edge before polling so the last accepted item is counted as pending
    task automatic drain_pipeline();
        sample_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [19:0] t_corner [4];
        logic [15:0] h_corner [4];
        logic [19:0] rt;
        logic [15:0] rh;
        cal_kind_t   kind;
        t_corner = '{20'h00000, 20'hFFFFF, 20'd519888, 20'h80000};
        h_corner = '{16'h0000, 16'hFFFF, 16'd30000, 16'h8000};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // reset calibration (all zero)
        send_sample(20'h00000, 16'h0000);
        send_sample(20'hFFFFF, 16'hFFFF);
        drain_pipeline();

        // typical part: humidity floor and ceiling clamps show up at raw_h extremes
        load_cal(make_cal(CAL_DATASHEET));
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_sample(t_corner[i], h_corner[j]);
        drain_pipeline();

        // extreme calibrations drive the intermediates into wraparound
        load_cal(make_cal(CAL_MAX));
        send_sample(20'hFFFFF, 16'hFFFF);
        send_sample(20'h00000, 16'h0000);
        drain_pipeline();
        load_cal(make_cal(CAL_MIN));
        send_sample(20'hFFFFF, 16'h0000);
        send_sample(20'h00000, 16'hFFFF);
        drain_pipeline();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                3:       kind = CAL_MAX;
                7:       kind = CAL_MIN;
                10:      kind = CAL_DATASHEET;
                default: kind = (ph % 3 == 2) ? CAL_WIDE : CAL_NEAR;
            endcase
            load_cal(make_cal(kind));
            repeat (128)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    rt = 20'($urandom_range(350000, 650000));
                    rh = 16'($urandom_range(10000, 50000));
                end
                else
                begin
                    rt = 20'($urandom_range(0, 20'hFFFFF));
                    rh = 16'($urandom_range(0, 16'hFFFF));
                end
                send_sample(rt, rh);
            end
            drain_pipeline();
        end

        repeat (htsc_pkg::STAGES + 4) @(posedge clk);

        $display("Sent %0d items across %0d calibration settings, %0d results compared.",
                 samples_sent, settings_loaded, checked);
        $display("Humidity at zero %0d times, at full scale %0d times.", zero_hits, full_hits);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
